### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define SHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define SHC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/shc_pkg.sv
// ----------------------------------------------------------------------------
// shc_pkg
// Types and constants shared by the strip hit clustering modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shc_pkg;

    // Field widths
    localparam int DET_W     = 4;
    localparam int STRIP_W   = 8;
    localparam int ADC_W     = 10;
    localparam int PED_W     = 14;
    localparam int RMS_W     = 14;
    localparam int SMP_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CHG_W     = 14;
    localparam int SUM_W     = 22;
    localparam int SIZE_W    = 9;
    localparam int REGION_W  = 6;
    localparam int NUM_RES   = 4;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    // Saturation limits
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // Register reset values
    localparam logic [CFG_W-1:0] N_SIGMA_RST = 10'd80;
    localparam logic [CFG_W-1:0] SIG_LO_RST  = 10'd15;
    localparam logic [CFG_W-1:0] SIG_HI_RST  = 10'd40;
    localparam logic [CFG_W-1:0] BG_LO_RST   = 10'd5;
    localparam logic [CFG_W-1:0] BG_HI_RST   = 10'd15;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_SIGMA = 3'd0,
        CFG_SIG_LO  = 3'd1,
        CFG_SIG_HI  = 3'd2,
        CFG_BG_LO   = 3'd3,
        CFG_BG_HI   = 3'd4
    } shc_cfg_idx_t;

    // Input beat layout, lowest field in the lowest bits
    typedef struct packed {
        logic [3:0]         pad;
        logic [SMP_W-1:0]   peak_sample;
        logic [RMS_W-1:0]   rms_x16;
        logic [PED_W-1:0]   pedestal_x16;
        logic [ADC_W-1:0]   adc_max;
        logic [STRIP_W-1:0] strip;
        logic [DET_W-1:0]   detector_id;
    } shc_s_tdata_t;

    // Output beat layout, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]          pad;
        logic [STRIP_W-1:0]  peak_strip;
        logic [SUM_W-1:0]    charge_total_x16;
        logic [SIZE_W-1:0]   cluster_size;
        logic [REGION_W-1:0] region_num;
        logic [DET_W-1:0]    cluster_detector;
    } shc_m_tdata_t;

    // Qualified strip handed to the cluster trackers
    typedef struct packed {
        logic [DET_W-1:0]   det;
        logic [STRIP_W-1:0] strip;
        logic [CHG_W-1:0]   charge;
        logic               qsig;
        logic               qbg;
        logic               last;
    } shc_item_t;

    // One closed cluster
    typedef struct packed {
        logic                sig_flag;
        logic [DET_W-1:0]    det;
        logic [REGION_W-1:0] region;
        logic [SIZE_W-1:0]   size;
        logic [SUM_W-1:0]    charge;
        logic [STRIP_W-1:0]  peak;
    } shc_result_t;

    // Clusters closed by one strip in one class
    typedef struct packed {
        logic        gap_vld;
        shc_result_t gap_res;
        logic        last_vld;
        shc_result_t last_res;
    } shc_close_t;

endpackage

`default_nettype wire

### rtl/shc_qualify.sv
// ----------------------------------------------------------------------------
// shc_qualify
// Input register, threshold and window tests, charge, and the qualified
// strip register. Also holds the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module shc_qualify (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [shc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [shc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [shc_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                         s_tlast,
    input  wire logic                         dn_ready,
    output logic                              q_valid,
    output shc_pkg::shc_item_t                q_item
);
    import shc_pkg::*;

    logic [CFG_W-1:0] n_sigma_reg, sig_lo_reg, sig_hi_reg, bg_lo_reg, bg_hi_reg;

    shc_s_tdata_t in_reg;
    logic         in_last_reg;
    logic         in_vld_reg, in_vld_next;

    shc_item_t    q_reg, q_next;
    logic         q_vld_reg, q_vld_next;
    logic         q_rdy;

    logic [23:0]      prod;
    logic [24:0]      thr, lhs;
    logic             above;
    logic [CHG_W-1:0] adc16;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_sigma_reg <= N_SIGMA_RST;
            sig_lo_reg  <= SIG_LO_RST;
            sig_hi_reg  <= SIG_HI_RST;
            bg_lo_reg   <= BG_LO_RST;
            bg_hi_reg   <= BG_HI_RST;
        end else if (cfg_wr_en) begin
            unique case (shc_cfg_idx_t'(cfg_wr_index))
                CFG_N_SIGMA: n_sigma_reg <= cfg_wr_data;
                CFG_SIG_LO:  sig_lo_reg  <= cfg_wr_data;
                CFG_SIG_HI:  sig_hi_reg  <= cfg_wr_data;
                CFG_BG_LO:   bg_lo_reg   <= cfg_wr_data;
                CFG_BG_HI:   bg_hi_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Stage handshakes
    assign q_rdy       = !q_vld_reg || dn_ready;
    assign s_tready    = !in_vld_reg || q_rdy;
    assign in_vld_next = s_tready ? s_tvalid : in_vld_reg;
    assign q_vld_next  = q_rdy ? in_vld_reg : q_vld_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg      <= shc_s_tdata_t'(s_tdata);
            in_last_reg <= s_tlast;
        end
    end

    // adc*256 > ped*16 + n_sigma*rms, all in 1/256 ADC
    always_comb begin
        prod  = 24'(n_sigma_reg) * 24'(in_reg.rms_x16);
        thr   = 25'({in_reg.pedestal_x16, 4'b0000}) + 25'(prod);
        lhs   = 25'({in_reg.adc_max, 8'h00});
        above = (in_reg.rms_x16 != '0) && (lhs > thr);
        adc16 = {in_reg.adc_max, 4'b0000};
    end

    // Charge and window tests
    always_comb begin
        q_next.det    = in_reg.detector_id;
        q_next.strip  = in_reg.strip;
        q_next.charge = (adc16 > in_reg.pedestal_x16) ? adc16 - in_reg.pedestal_x16 : '0;
        q_next.qsig   = above && (in_reg.peak_sample >= sig_lo_reg)
                              && (in_reg.peak_sample < sig_hi_reg);
        q_next.qbg    = above && (in_reg.peak_sample >= bg_lo_reg)
                              && (in_reg.peak_sample < bg_hi_reg);
        q_next.last   = in_last_reg;
    end

    // Qualified strip register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
        end else begin
            q_vld_reg <= q_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_vld_reg && q_rdy) begin
            q_reg <= q_next;
        end
    end

    assign q_valid = q_vld_reg;
    assign q_item  = q_reg;

endmodule

`default_nettype wire

### rtl/shc_cluster_track.sv
// ----------------------------------------------------------------------------
// shc_cluster_track
// Open-cluster state for one class (signal or background). Extends, closes
// and restarts the cluster for each accepted strip.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module shc_cluster_track #(
    parameter int STRIPS_PER_REGION    = 64,
    parameter int REGIONS_PER_DETECTOR = 4,
    parameter bit IS_SIGNAL            = 1'b1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fire,
    input  wire logic          qual,
    input  shc_pkg::shc_item_t item,
    output shc_pkg::shc_close_t close
);
    import shc_pkg::*;

    localparam int NSTRIPS = 2 ** STRIP_W;

    logic               active_reg, active_next;
    logic [DET_W-1:0]   det_reg, det_next;
    logic [STRIP_W-1:0] prev_reg, prev_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CHG_W-1:0]   pk_reg, pk_next;
    logic [STRIP_W-1:0] pks_reg, pks_next;

    logic [STRIP_W-1:0] region_lut [NSTRIPS];
    logic               gap, start, open_after;
    logic [SUM_W:0]     sum_wide;

    // Strip number to region within the detector
    for (genvar g = 0; g < NSTRIPS; g++) begin : g_lut
        assign region_lut[g] = STRIP_W'(g / STRIPS_PER_REGION);
    end

    // Next state
    always_comb begin
        gap        = qual && active_reg && ((det_reg != item.det) ||
                     ({1'b0, item.strip} > ({1'b0, prev_reg} + 9'd1)));
        start      = qual && (!active_reg || gap);
        open_after = qual || active_reg;
        sum_wide   = {1'b0, sum_reg} + (SUM_W + 1)'(item.charge);

        det_next  = det_reg;
        prev_next = prev_reg;
        size_next = size_reg;
        sum_next  = sum_reg;
        pk_next   = pk_reg;
        pks_next  = pks_reg;

        if (start) begin
            det_next  = item.det;
            size_next = SIZE_W'(1);
            sum_next  = SUM_W'(item.charge);
            pk_next   = item.charge;
            pks_next  = item.strip;
        end else if (qual) begin
            if (size_reg != SIZE_MAX) begin
                size_next = size_reg + SIZE_W'(1);
            end
            sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            if (item.charge > pk_reg) begin
                pk_next  = item.charge;
                pks_next = item.strip;
            end
        end
        if (qual) begin
            prev_next = item.strip;
        end
        active_next = open_after && !item.last;
    end

    // Closed clusters: a gap closes the old one, the last flag the updated one
    always_comb begin
        close.gap_vld          = gap;
        close.gap_res.sig_flag = IS_SIGNAL;
        close.gap_res.det      = det_reg;
        close.gap_res.region   = REGION_W'(32'(region_lut[pks_reg]) +
                                           REGIONS_PER_DETECTOR * 32'(det_reg));
        close.gap_res.size     = size_reg;
        close.gap_res.charge   = sum_reg;
        close.gap_res.peak     = pks_reg;

        close.last_vld          = item.last && open_after;
        close.last_res.sig_flag = IS_SIGNAL;
        close.last_res.det      = det_next;
        close.last_res.region   = REGION_W'(32'(region_lut[pks_next]) +
                                            REGIONS_PER_DETECTOR * 32'(det_next));
        close.last_res.size     = size_next;
        close.last_res.charge   = sum_next;
        close.last_res.peak     = pks_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (fire) begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            det_reg  <= det_next;
            prev_reg <= prev_next;
            size_reg <= size_next;
            sum_reg  <= sum_next;
            pk_reg   <= pk_next;
            pks_reg  <= pks_next;
        end
    end

    // A qualified strip without the last flag leaves a cluster open
    `SHC_ASSERT_NEXT(a_open_after_qual, fire && qual && !item.last, active_reg, "cluster not open")
    // An open cluster always holds at least one strip
    `SHC_ASSERT_IMPL(a_open_size, active_reg, size_reg != '0, "open cluster with zero size")

endmodule

`default_nettype wire

### rtl/shc_result_out.sv
// ----------------------------------------------------------------------------
// shc_result_out
// Collects the clusters closed by one strip into a result buffer and sends
// them out one beat at a time, in order, last beat flagged.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module shc_result_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire logic [shc_pkg::NUM_RES-1:0]   res_vld,
    input  shc_pkg::shc_result_t               res [shc_pkg::NUM_RES],
    output logic                               load_ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [shc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import shc_pkg::*;

    localparam int PTR_W = $clog2(NUM_RES);
    localparam int CNT_W = $clog2(NUM_RES + 1);

    shc_result_t      slot_reg [NUM_RES];
    shc_result_t      pack     [NUM_RES];
    logic [CNT_W-1:0] cnt_reg, cnt_next, pack_cnt;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             beat, done;
    shc_result_t      cur;
    shc_m_tdata_t     tdata;

    // Compact the valid results to the front, keeping order
    always_comb begin
        pack_cnt = '0;
        for (int i = 0; i < NUM_RES; i++) begin
            pack[i] = res[i];
        end
        for (int i = 0; i < NUM_RES; i++) begin
            if (res_vld[i]) begin
                pack[pack_cnt[PTR_W-1:0]] = res[i];
                pack_cnt = pack_cnt + CNT_W'(1);
            end
        end
    end

    // Output handshake
    assign cur        = slot_reg[ptr_reg];
    assign m_tvalid   = (cnt_reg != '0);
    assign m_tlast    = (CNT_W'(ptr_reg) + CNT_W'(1)) == cnt_reg;
    assign beat       = m_tvalid && m_tready;
    assign done       = beat && m_tlast;
    assign load_ready = (cnt_reg == '0) || done;

    always_comb begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (load) begin
            cnt_next = pack_cnt;
            ptr_next = '0;
        end else if (done) begin
            cnt_next = '0;
        end else if (beat) begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_RES; i++) begin
                slot_reg[i] <= pack[i];
            end
        end
    end

    // Beat formatting
    always_comb begin
        tdata.pad              = '0;
        tdata.peak_strip       = cur.peak;
        tdata.charge_total_x16 = cur.charge;
        tdata.cluster_size     = cur.size;
        tdata.region_num       = cur.region;
        tdata.cluster_detector = cur.det;
    end

    assign m_tdata = M_TDATA_W'(tdata);
    assign m_tuser = cur.sig_flag;

    // A burst of results continues until its flagged beat
    `SHC_ASSERT_NEXT(a_burst_continues, beat && !m_tlast, m_tvalid, "result burst cut short")
    // The read pointer stays inside the buffered results
    `SHC_ASSERT_IMPL(a_ptr_in_range, cnt_reg != '0, CNT_W'(ptr_reg) < cnt_reg, "bad read pointer")
    // Buffer never claims more results than one strip can close
    `SHC_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(NUM_RES), "result count overflow")

endmodule

`default_nettype wire

### rtl/strip_hit_clustering_unit.sv
// ----------------------------------------------------------------------------
// strip_hit_clustering_unit
// Adjacent-strip cluster finder: one strip summary in, closed signal and
// background clusters out.
// ----------------------------------------------------------------------------
// Accepts one strip summary per clock unless stalled. A strip passes an input
// register, a threshold/window stage and the cluster-state update before its
// results reach the output buffer. Each closed cluster is one output beat, and
// a strip closes zero to four clusters (signal before background, gap-closed
// before last-closed), the final beat of a strip marked by m_tlast. The output
// port moves one result per cycle while m_tready is high, so a strip's results
// hold the buffer until its last beat is taken; with at most one result per
// strip the block then runs at a full strip per clock. Configuration writes
// take effect at once and must be made while idle; the block does not check.
`default_nettype none

module strip_hit_clustering_unit #(
    parameter int STRIPS_PER_REGION    = 64,
    parameter int REGIONS_PER_DETECTOR = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [shc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [shc_pkg::CFG_W-1:0]      cfg_wr_data,
    // Strip summaries
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // detector_id[3:0], strip[11:4], adc_max[21:12], pedestal_x16[35:22],
    // rms_x16[49:36], peak_sample[59:50], zero fill [63:60]
    input  wire logic [shc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tlast,   // last_of_detector
    // Closed clusters
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // cluster_detector[3:0], region_num[9:4], cluster_size[18:10],
    // charge_total_x16[40:19], peak_strip[48:41], zero fill [55:49]
    output logic [shc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tuser,   // sig_flag
    output logic                                m_tlast    // last result of a strip
);
    import shc_pkg::*;

    logic        q_valid, load_ready, fire;
    shc_item_t   q_item;
    shc_close_t  sig_close, bg_close;
    logic [NUM_RES-1:0] res_vld;
    shc_result_t res [NUM_RES];

    shc_qualify u_qualify (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .dn_ready     (load_ready),
        .q_valid      (q_valid),
        .q_item       (q_item)
    );

    assign fire = q_valid && load_ready;

    shc_cluster_track #(
        .STRIPS_PER_REGION    (STRIPS_PER_REGION),
        .REGIONS_PER_DETECTOR (REGIONS_PER_DETECTOR),
        .IS_SIGNAL            (1'b1)
    ) u_sig_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .qual    (q_item.qsig),
        .item    (q_item),
        .close   (sig_close)
    );

    shc_cluster_track #(
        .STRIPS_PER_REGION    (STRIPS_PER_REGION),
        .REGIONS_PER_DETECTOR (REGIONS_PER_DETECTOR),
        .IS_SIGNAL            (1'b0)
    ) u_bg_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .qual    (q_item.qbg),
        .item    (q_item),
        .close   (bg_close)
    );

    // Result order: signal gap, signal last, background gap, background last
    assign res_vld = {bg_close.last_vld, bg_close.gap_vld,
                      sig_close.last_vld, sig_close.gap_vld};
    assign res[0]  = sig_close.gap_res;
    assign res[1]  = sig_close.last_res;
    assign res[2]  = bg_close.gap_res;
    assign res[3]  = bg_close.last_res;

    shc_result_out u_result_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .res_vld    (res_vld),
        .res        (res),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
